FILE: src/hpe_pkg.sv
`default_nettype none

package hpe_pkg;

  // Longest code in the static table and the widest packed group it can produce.
  localparam int unsigned MaxCodeLen = 30;
  localparam int unsigned MaxBytes   = 5;
  localparam int unsigned GroupBits  = 8 * MaxBytes;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
  } out_item_t;

  // Packed bytes of one item, first byte in the top octet.
  typedef struct packed {
    logic [GroupBits-1:0] data;
    logic [2:0]           count;
    logic                 last;
  } group_t;

  typedef logic [0:255][4:0]            len_rom_t;
  typedef logic [0:255][MaxCodeLen-1:0] code_rom_t;

  // Code lengths of the static Huffman table, indexed by octet value.
  localparam len_rom_t LenRom = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6,  5'd10, 5'd10, 5'd12, 5'd13, 5'd6,  5'd8,  5'd11,
    5'd10, 5'd10, 5'd8,  5'd11, 5'd8,  5'd6,  5'd6,  5'd6,
    5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
    5'd6,  5'd6,  5'd7,  5'd8,  5'd15, 5'd6,  5'd12, 5'd10,
    5'd13, 5'd6,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
    5'd8,  5'd7,  5'd8,  5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5,  5'd6,  5'd5,  5'd6,  5'd5,  5'd6,  5'd6,
    5'd6,  5'd5,  5'd7,  5'd7,  5'd6,  5'd6,  5'd6,  5'd5,
    5'd6,  5'd7,  5'd6,  5'd5,  5'd5,  5'd6,  5'd7,  5'd7,
    5'd7,  5'd7,  5'd7,  5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

  // Canonical codes from the length table: shorter codes first, then octet order.
  // Only evaluated at elaboration to build the constant code table.
  function automatic code_rom_t build_codes();
    code_rom_t            rom;
    logic [MaxCodeLen-1:0] code;
    rom  = '0;
    code = '0;
    for (int len = 1; len <= MaxCodeLen; len++) begin
      for (int s = 0; s < 256; s++) begin
        if (int'(LenRom[s]) == len) begin
          rom[s] = code;
          code   = code + 1'b1;
        end
      end
      code = code << 1;
    end
    return rom;
  endfunction

  localparam code_rom_t CodeRom = build_codes();

endpackage

`default_nettype wire

FILE: src/hpe_pack.sv
`default_nettype none

module hpe_pack
  import hpe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     take_i,
  input  wire in_item_t item_i,
  output group_t        group_o
);

  localparam int unsigned AccBits = MaxCodeLen + 7;

  logic [6:0]            left_bits_q, left_bits_d;
  logic [2:0]            left_cnt_q,  left_cnt_d;

  logic [4:0]            len;
  logic [MaxCodeLen-1:0] code;
  logic [AccBits-1:0]    acc;
  logic [5:0]            total;
  logic [5:0]            align;
  logic [GroupBits-1:0]  aligned;
  logic [GroupBits-1:0]  pad;
  logic [2:0]            rem;
  logic                  has_pad;
  logic [6:0]            keep_mask;

  // Table lookup and append of the code below the pending bits.
  always_comb begin
    len   = LenRom[item_i.symbol];
    code  = CodeRom[item_i.symbol];
    acc   = ({{(AccBits-7){1'b0}}, left_bits_q} << len) | {7'b0, code};
    total = {3'b0, left_cnt_q} + {1'b0, len};
    rem   = total[2:0];
  end

  // Left-align the pending bits in the group word and pad a partial last octet with ones.
  always_comb begin
    align     = 6'(GroupBits) - total;
    aligned   = {{(GroupBits-AccBits){1'b0}}, acc} << align;
    pad       = {GroupBits{1'b1}} >> total;
    has_pad   = item_i.end_of_string && (rem != 3'd0);
    group_o.data  = has_pad ? (aligned | pad) : aligned;
    group_o.count = total[5:3] + {2'b0, has_pad};
    group_o.last  = item_i.end_of_string;
  end

  // Bits that do not fill an octet wait for the next item, unless the string ends.
  always_comb begin
    keep_mask = 7'h7f >> (3'd7 - rem);
    if (item_i.end_of_string) begin
      left_bits_d = '0;
      left_cnt_d  = '0;
    end else begin
      left_bits_d = acc[6:0] & keep_mask;
      left_cnt_d  = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_bits_q <= '0;
      left_cnt_q  <= '0;
    end else if (take_i) begin
      left_bits_q <= left_bits_d;
      left_cnt_q  <= left_cnt_d;
    end
  end

  // The end of a string always flushes the pending bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.end_of_string |=> left_cnt_q == 3'd0 && left_bits_q == 7'd0)
    else $error("pending bits survived the end of a string");

  // Pending bits never exceed their count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (left_bits_q & ~(7'h7f >> (3'd7 - left_cnt_q))) == 7'd0)
    else $error("stray pending bits above the count");

  // A string end always yields at least one octet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i && item_i.end_of_string |-> group_o.count != 3'd0)
    else $error("string end produced no octet");

endmodule

`default_nettype wire

FILE: src/hpack_huffman_encoder_top.sv
// Static HPACK Huffman string encoder.
// Input channel (in_valid_i, in_stall_o, in_item_i) takes one octet of a header
// string per item, with end_of_string set on its final octet. Output channel
// (out_valid_o, out_stall_i, out_item_o) gives the packed code octets, earliest
// code bits in the high positions, with last_byte set on the final octet of
// the string; a partial final octet is padded with one bits.
// Latency: the first octet of an item is presented in the cycle after it is
// accepted. One item yields zero to five octets, which the byte-wide output
// register gives out one at a time; typical text, with codes of five to eight
// bits, yields about one octet per item, while long codes yield up to five.
// An item is accepted in the same cycle as the last octet of the previous
// one leaves, so there is no bubble between items.
// When the receiver stalls, the current octet is held unchanged and the
// input stalls as soon as the output register has more to give.
// Reset clears the pending bits and empties the output register.
`default_nettype none

module hpack_huffman_encoder_top
  import hpe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  logic                 in_take;
  logic                 out_take;
  group_t               grp;
  logic [GroupBits-1:0] data_q, data_d;
  logic [2:0]           cnt_q,  cnt_d;
  logic                 last_q, last_d;

  // The output register frees up when it is empty or its final octet leaves.
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign in_stall_o  = (cnt_q > 3'd1) || ((cnt_q == 3'd1) && out_stall_i);
  assign in_take     = in_valid_i && !in_stall_o;

  hpe_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (in_take),
    .item_i  (in_item_i),
    .group_o (grp)
  );

  // Load a new group or shift out one octet.
  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    if (in_take) begin
      data_d = grp.data;
      cnt_d  = grp.count;
      last_d = grp.last;
    end else if (out_take) begin
      data_d = data_q << 8;
      cnt_d  = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      last_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_item_o.code_byte = data_q[GroupBits-1 -: 8];
  assign out_item_o.last_byte = last_q && (cnt_q == 3'd1);

  // The output register never holds more than one item's octets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(MaxBytes))
    else $error("octet count out of range");

  // A new item only enters when the previous group is gone or leaving.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take && (cnt_q != 3'd0) |-> (cnt_q == 3'd1) && out_take)
    else $error("item accepted over pending octets");

  // After a string's final octet leaves, nothing is pending until a new item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && out_item_o.last_byte && !in_take |=> !out_valid_o)
    else $error("octets remain after the end of a string");

endmodule

`default_nettype wire
